// ----- hdl/hbs_pkg.sv -----
// ----------------------------------------------------------------------------
// hbs_pkg
// Shared constants, register codes and widths for the height-map sampler.
// ----------------------------------------------------------------------------
package hbs_pkg;

    localparam int DEF_MAX_WIDTH_LOG2 = 8;
    localparam int DEF_MAX_HEIGHT     = 256;

    // Q16.16 fraction bits
    localparam int FRAC_BITS = 16;

    // Divisor of the coordinate mapping: twice a 32-bit box dimension
    localparam int DIV_DW = 33;

    // Texel and beat widths
    localparam int TEXEL_W    = 24;
    localparam int IN_DATA_W  = 72;
    localparam int OUT_DATA_W = 32;

    // Register reset values
    localparam logic [3:0]  RST_WIDTH_LOG2 = 4'd8;
    localparam logic [8:0]  RST_HEIGHT     = 9'd256;
    localparam logic        RST_PRECISION  = 1'b1;
    localparam logic [31:0] RST_DIM_X      = 32'h0001_0000;
    localparam logic [31:0] RST_DIM_Z      = 32'h0001_0000;
    localparam logic [31:0] RST_DIM_Y      = 32'h0001_0000;
    localparam logic [31:0] RST_MIN_Y      = 32'h0000_0000;

    typedef enum logic [2:0] {
        REG_WIDTH_LOG2 = 3'd0,
        REG_HEIGHT     = 3'd1,
        REG_PRECISION  = 3'd2,
        REG_DIM_X      = 3'd3,
        REG_DIM_Z      = 3'd4,
        REG_DIM_Y      = 3'd5,
        REG_MIN_Y      = 3'd6
    } cfg_reg_t;

endpackage

// ----- hdl/hbs_coord_div.sv -----
// ----------------------------------------------------------------------------
// hbs_coord_div
// Pipelined restoring divider, one quotient bit per stage, for the texel
// coordinate mapping.
// ----------------------------------------------------------------------------
module hbs_coord_div #(
    parameter int RW = 66,
    parameter int QB = 24
)(
    input  logic                        clk,
    input  logic                        adv,
    input  logic [RW-1:0]               dividend,
    input  logic [hbs_pkg::DIV_DW-1:0]  divisor,
    output logic [QB-1:0]               quotient
);

    logic [RW-1:0] rem_reg [QB];
    logic [QB-1:0] quo_reg [QB];

    for (genvar j = 0; j < QB; j++)
    begin : g_stage
        logic [RW-1:0] rin;
        logic [QB-1:0] qin;
        logic [RW-1:0] trial;

        if (j == 0)
        begin : g_first
            assign rin = dividend;
            assign qin = '0;
        end
        else
        begin : g_next
            assign rin = rem_reg[j-1];
            assign qin = quo_reg[j-1];
        end

        // divisor aligned to quotient bit QB-1-j
        assign trial = RW'(divisor) << (QB - 1 - j);

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                if (rin >= trial)
                begin
                    rem_reg[j] <= rin - trial;
                    quo_reg[j] <= qin | (QB'(1) << (QB - 1 - j));
                end
                else
                begin
                    rem_reg[j] <= rin;
                    quo_reg[j] <= qin;
                end
            end
        end
    end

    assign quotient = quo_reg[QB-1];

endmodule

// ----- hdl/heightmap_bilinear_sampler.sv -----
// ----------------------------------------------------------------------------
// heightmap_bilinear_sampler
// Height-map store with bilinear height lookup in Q16.16.
// ----------------------------------------------------------------------------
// The sampler takes one beat per clock while the output buffer has room and
// returns exactly one result beat for each, in order. A write beat (tuser = 1)
// stores one texel and returns height 0; a query beat (tuser = 0) maps model
// (x, z) onto the map, reads the four neighbor texels and returns the blended,
// scaled world height, or outside_map = 1 with height 0 when the point is off
// the map. The coordinate dividers have QB stages, one quotient bit each, where
// QB = 16 plus the larger of MAX_WIDTH_LOG2 and clog2(MAX_HEIGHT). The texel
// store is split into two banks by the lowest address bit, each with two read
// ports, so the four neighbors are read in the same cycle. Writes and reads
// happen at the same pipeline stage, so a query always sees every write
// accepted before it. The whole pipeline holds only when the two-entry output
// buffer is full. The texel store has no clearing pass; only entries that were
// written may be read. Configuration must be written while the sampler is
// drained.
// ----------------------------------------------------------------------------
module heightmap_bilinear_sampler #(
    parameter int MAX_WIDTH_LOG2 = hbs_pkg::DEF_MAX_WIDTH_LOG2,
    parameter int MAX_HEIGHT     = hbs_pkg::DEF_MAX_HEIGHT
)(
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration write port
    input  logic                              cfg_we,
    input  logic [2:0]                        cfg_addr,
    input  logic [31:0]                       cfg_data,
    // input stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [hbs_pkg::IN_DATA_W-1:0]     s_tdata,  // model_x, model_z, texel_addr,
                                                        // texel_value
    input  logic [0:0]                        s_tuser,  // action
    // result stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [hbs_pkg::OUT_DATA_W-1:0]    m_tdata,  // height
    output logic [0:0]                        m_tuser   // outside_map
);

    localparam int FB    = hbs_pkg::FRAC_BITS;
    localparam int TW    = hbs_pkg::TEXEL_W;
    localparam int HB    = $clog2(MAX_HEIGHT);
    localparam int ZIB   = (HB < 1) ? 1 : HB;
    localparam int IW    = (MAX_WIDTH_LOG2 > HB) ? MAX_WIDTH_LOG2 : HB;
    localparam int QB    = FB + IW;
    localparam int XSPW  = MAX_WIDTH_LOG2 + 1;
    localparam int ZSPW  = $clog2(MAX_HEIGHT + 1);
    localparam int SPW   = (XSPW > ZSPW) ? XSPW : ZSPW;
    localparam int NMW   = 34;
    localparam int MW    = NMW + SPW;
    localparam int RW    = MW + FB;
    localparam int DW    = hbs_pkg::DIV_DW;
    localparam int LW    = DW + SPW;
    localparam int STORE_DEPTH = (1 << MAX_WIDTH_LOG2) * MAX_HEIGHT;
    localparam int AW    = $clog2(STORE_DEPTH);
    localparam int BAW   = (AW > 1) ? AW - 1 : 1;
    localparam int BD    = STORE_DEPTH / 2;
    localparam int DIG_N = 6;

    typedef struct packed {
        logic valid;
        logic wr;
        logic outside;
    } flag_t;

    typedef struct packed {
        flag_t        f;
        logic [15:0]  x;
        logic [15:0]  z;
        logic [15:0]  addr;
        logic [TW-1:0] value;
    } p1_t;

    typedef struct packed {
        flag_t        f;
        logic [NMW-1:0] nx;
        logic [NMW-1:0] nz;
        logic [15:0]  addr;
        logic [TW-1:0] value;
    } p2_t;

    typedef struct packed {
        flag_t        f;
        logic [MW-1:0] mx;
        logic [MW-1:0] mz;
        logic [LW-1:0] limx;
        logic [LW-1:0] limz;
        logic [15:0]  addr;
        logic [TW-1:0] value;
    } p3_t;

    typedef struct packed {
        flag_t        f;
        logic [15:0]  addr;
        logic [TW-1:0] value;
    } side_t;

    typedef struct packed {
        flag_t               f;
        logic                dx;
        logic [FB-1:0]       xf;
        logic [FB-1:0]       zf;
        logic [3:0]          sel;     // bank of h00, h10, h01, h11 (bit 0 up)
        logic [1:0][BAW-1:0] ra_idx;
        logic [1:0][BAW-1:0] rb_idx;
        logic                wok;
        logic                wbank;
        logic [BAW-1:0]      widx;
        logic [TW-1:0]       wvalue;
    } sta_t;

    typedef struct packed {
        flag_t         f;
        logic [FB-1:0] xf;
        logic [FB-1:0] zf;
        logic [3:0]    sel;
    } str_t;

    typedef struct packed {
        flag_t         f;
        logic [40:0]   top;
        logic [40:0]   bot;
        logic [FB-1:0] zf;
    } b1_t;

    typedef struct packed {
        flag_t              f;
        logic [40:0]        top;
        logic [36:0]        lo;
        logic signed [37:0] hi;
    } b2_t;

    typedef struct packed {
        flag_t       f;
        logic [23:0] val;
    } b3_t;

    typedef struct packed {
        flag_t       f;
        logic [39:0] plo;
        logic [39:0] phi;
    } c1_t;

    typedef struct packed {
        flag_t       f;
        logic [47:0] y;
        logic [7:0]  rem;
        logic [47:0] q;
    } dig_t;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [3:0]  wl_reg;
    logic [8:0]  h_reg;
    logic        prec_reg;
    logic [31:0] dimx_reg;
    logic [31:0] dimz_reg;
    logic [31:0] dimy_reg;
    logic [31:0] miny_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wl_reg   <= hbs_pkg::RST_WIDTH_LOG2;
            h_reg    <= hbs_pkg::RST_HEIGHT;
            prec_reg <= hbs_pkg::RST_PRECISION;
            dimx_reg <= hbs_pkg::RST_DIM_X;
            dimz_reg <= hbs_pkg::RST_DIM_Z;
            dimy_reg <= hbs_pkg::RST_DIM_Y;
            miny_reg <= hbs_pkg::RST_MIN_Y;
        end
        else if (cfg_we)
        begin
            case (hbs_pkg::cfg_reg_t'(cfg_addr))
                hbs_pkg::REG_WIDTH_LOG2: wl_reg   <= cfg_data[3:0];
                hbs_pkg::REG_HEIGHT:     h_reg    <= cfg_data[8:0];
                hbs_pkg::REG_PRECISION:  prec_reg <= cfg_data[0];
                hbs_pkg::REG_DIM_X:      dimx_reg <= cfg_data;
                hbs_pkg::REG_DIM_Z:      dimz_reg <= cfg_data;
                hbs_pkg::REG_DIM_Y:      dimy_reg <= cfg_data;
                hbs_pkg::REG_MIN_Y:      miny_reg <= cfg_data;
                default:                 ;  // unmapped index: drop
            endcase
        end
    end

    // Clamp width and height to what the store was built for
    logic [3:0]      wl_eff;
    logic [XSPW-1:0] w_span;
    logic [ZSPW-1:0] h_eff;

    assign wl_eff = (32'(wl_reg) > 32'(MAX_WIDTH_LOG2)) ? 4'(MAX_WIDTH_LOG2) : wl_reg;
    assign w_span = XSPW'(1) << wl_eff;
    assign h_eff  = (32'(h_reg) > 32'(MAX_HEIGHT)) ? ZSPW'(MAX_HEIGHT) : ZSPW'(h_reg);

    // ------------------------------------------------------------------
    // Pipeline advance: hold everything only when the output buffer is full
    // ------------------------------------------------------------------
    logic [1:0] cnt_reg;
    logic       adv;

    assign adv      = (cnt_reg != 2'd2);
    assign s_tready = adv;

    // ------------------------------------------------------------------
    // P1: capture the input beat
    // ------------------------------------------------------------------
    p1_t p1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p1_reg <= '0;
        else if (adv)
        begin
            p1_reg.f.valid   <= s_tvalid;
            p1_reg.f.wr      <= s_tuser[0];
            p1_reg.f.outside <= 1'b0;
            p1_reg.x         <= s_tdata[15:0];
            p1_reg.z         <= s_tdata[31:16];
            p1_reg.addr      <= s_tdata[47:32];
            p1_reg.value     <= s_tdata[71:48];
        end
    end

    // ------------------------------------------------------------------
    // P2: numerators dim + 2x and dim - 2z in Q16.16, sign screening
    // ------------------------------------------------------------------
    logic signed [34:0] nx;
    logic signed [34:0] nz;
    logic               p2_out;
    p2_t                p2_reg;

    assign nx = $signed({3'b000, dimx_reg}) + $signed({{2{p1_reg.x[15]}}, p1_reg.x, 17'd0});
    assign nz = $signed({3'b000, dimz_reg}) - $signed({{2{p1_reg.z[15]}}, p1_reg.z, 17'd0});

    // a negative numerator is off the map unless the span is a single texel
    assign p2_out = (dimx_reg == '0) || (dimz_reg == '0) || (h_eff == '0)
                 || (nx[34] && (w_span != XSPW'(1)))
                 || (nz[34] && (h_eff != ZSPW'(1)));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p2_reg <= '0;
        else if (adv)
        begin
            p2_reg.f.valid   <= p1_reg.f.valid;
            p2_reg.f.wr      <= p1_reg.f.wr;
            p2_reg.f.outside <= p2_out;
            p2_reg.nx        <= nx[NMW-1:0];
            p2_reg.nz        <= nz[NMW-1:0];
            p2_reg.addr      <= p1_reg.addr;
            p2_reg.value     <= p1_reg.value;
        end
    end

    // ------------------------------------------------------------------
    // P3: scale numerators by span-1, bound = span * 2 * dim
    // ------------------------------------------------------------------
    p3_t p3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p3_reg <= '0;
        else if (adv)
        begin
            p3_reg.f     <= p2_reg.f;
            p3_reg.mx    <= MW'(p2_reg.nx) * MW'(w_span - XSPW'(1));
            p3_reg.mz    <= MW'(p2_reg.nz) * MW'(h_eff - ZSPW'(1));
            p3_reg.limx  <= LW'({dimx_reg, 1'b0}) * LW'(w_span);
            p3_reg.limz  <= LW'({dimz_reg, 1'b0}) * LW'(h_eff);
            p3_reg.addr  <= p2_reg.addr;
            p3_reg.value <= p2_reg.value;
        end
    end

    // ------------------------------------------------------------------
    // Coordinate dividers, with the item's side data alongside
    // ------------------------------------------------------------------
    logic [QB-1:0] qx;
    logic [QB-1:0] qz;
    side_t         side_reg [QB];
    logic          p3_over;

    // integer part would reach the span: off the map
    assign p3_over = (p3_reg.mx >= MW'(p3_reg.limx)) || (p3_reg.mz >= MW'(p3_reg.limz));

    hbs_coord_div #(.RW(RW), .QB(QB)) u_div_x (
        .clk      (clk),
        .adv      (adv),
        .dividend ({p3_reg.mx, {FB{1'b0}}}),
        .divisor  ({dimx_reg, 1'b0}),
        .quotient (qx)
    );

    hbs_coord_div #(.RW(RW), .QB(QB)) u_div_z (
        .clk      (clk),
        .adv      (adv),
        .dividend ({p3_reg.mz, {FB{1'b0}}}),
        .divisor  ({dimz_reg, 1'b0}),
        .quotient (qz)
    );

    for (genvar j = 0; j < QB; j++)
    begin : g_side
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                side_reg[j] <= '0;
            else if (adv)
            begin
                if (j == 0)
                begin
                    side_reg[j].f.valid   <= p3_reg.f.valid;
                    side_reg[j].f.wr      <= p3_reg.f.wr;
                    side_reg[j].f.outside <= p3_reg.f.outside || p3_over;
                    side_reg[j].addr      <= p3_reg.addr;
                    side_reg[j].value     <= p3_reg.value;
                end
                else
                    side_reg[j] <= side_reg[(j > 0) ? j - 1 : 0];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage A: neighbor addresses and bank read indexes
    // ------------------------------------------------------------------
    logic [MAX_WIDTH_LOG2-1:0] xi;
    logic [ZIB-1:0]            zi;
    logic                      dx;
    logic                      dy;
    logic [AW-1:0]             a;
    logic [AW-1:0]             a1;
    logic [AW-1:0]             b;
    logic [AW-1:0]             b1;
    logic [31:0]               waddr32;
    side_t                     sq;
    sta_t                      sta_reg;

    assign sq      = side_reg[QB-1];
    assign xi      = qx[FB +: MAX_WIDTH_LOG2];
    assign zi      = qz[FB +: ZIB];
    // clamp the right and lower neighbor at the last column and row
    assign dx      = (XSPW'(xi) + XSPW'(1)) != w_span;
    assign dy      = (32'(zi) + 32'd1) != 32'(h_eff);
    assign a       = (AW'(zi) << wl_eff) + AW'(xi);
    assign a1      = a + AW'(dx);
    assign b       = dy ? (a + (AW'(1) << wl_eff)) : a;
    assign b1      = b + AW'(dx);
    assign waddr32 = 32'(sq.addr);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sta_reg <= '0;
        else if (adv)
        begin
            sta_reg.f         <= sq.f;
            sta_reg.dx        <= dx;
            sta_reg.xf        <= qx[FB-1:0];
            sta_reg.zf        <= qz[FB-1:0];
            sta_reg.sel       <= {b1[0], b[0], a1[0], a[0]};
            sta_reg.ra_idx[0] <= BAW'(((a[0] == 1'b0) ? a : a1) >> 1);
            sta_reg.ra_idx[1] <= BAW'(((a[0] == 1'b1) ? a : a1) >> 1);
            sta_reg.rb_idx[0] <= BAW'(((b[0] == 1'b0) ? b : b1) >> 1);
            sta_reg.rb_idx[1] <= BAW'(((b[0] == 1'b1) ? b : b1) >> 1);
            sta_reg.wok       <= waddr32 < 32'(STORE_DEPTH);
            sta_reg.wbank     <= sq.addr[0];
            sta_reg.widx      <= BAW'(waddr32 >> 1);
            sta_reg.wvalue    <= sq.value;
        end
    end

    // ------------------------------------------------------------------
    // Texel store: two banks split on address bit 0, two read ports each.
    // Port A serves the upper row pair, port B the lower row pair.
    // ------------------------------------------------------------------
    logic [TW-1:0] rda_reg [2];
    logic [TW-1:0] rdb_reg [2];

    for (genvar p = 0; p < 2; p++)
    begin : g_bank
        logic [TW-1:0] mem [BD];

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                if (sta_reg.f.valid && sta_reg.f.wr && sta_reg.wok
                    && (sta_reg.wbank == 1'(p)))
                    mem[sta_reg.widx] <= sta_reg.wvalue;
                rda_reg[p] <= mem[sta_reg.ra_idx[p]];
                rdb_reg[p] <= mem[sta_reg.rb_idx[p]];
            end
        end
    end

    str_t str_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            str_reg <= '0;
        else if (adv)
        begin
            str_reg.f   <= sta_reg.f;
            str_reg.xf  <= sta_reg.xf;
            str_reg.zf  <= sta_reg.zf;
            str_reg.sel <= sta_reg.sel;
        end
    end

    // ------------------------------------------------------------------
    // Decode texels and blend along x
    // ------------------------------------------------------------------
    function automatic logic [TW-1:0] decode_texel(input logic [TW-1:0] raw, input logic prec);
        return prec ? raw : {raw[7:0], 16'd0};
    endfunction

    logic [TW-1:0]      h00;
    logic [TW-1:0]      h10;
    logic [TW-1:0]      h01;
    logic [TW-1:0]      h11;
    logic signed [24:0] dtop;
    logic signed [24:0] dbot;
    logic signed [41:0] top_s;
    logic signed [41:0] bot_s;
    b1_t                b1_reg;

    assign h00 = decode_texel(rda_reg[str_reg.sel[0]], prec_reg);
    assign h10 = decode_texel(rda_reg[str_reg.sel[1]], prec_reg);
    assign h01 = decode_texel(rdb_reg[str_reg.sel[2]], prec_reg);
    assign h11 = decode_texel(rdb_reg[str_reg.sel[3]], prec_reg);

    assign dtop  = $signed({1'b0, h10}) - $signed({1'b0, h00});
    assign dbot  = $signed({1'b0, h11}) - $signed({1'b0, h01});
    assign top_s = $signed({2'b00, h00, 16'd0}) + dtop * $signed({1'b0, str_reg.xf});
    assign bot_s = $signed({2'b00, h01, 16'd0}) + dbot * $signed({1'b0, str_reg.xf});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            b1_reg <= '0;
        else if (adv)
        begin
            b1_reg.f   <= str_reg.f;
            b1_reg.top <= top_s[40:0];
            b1_reg.bot <= bot_s[40:0];
            b1_reg.zf  <= str_reg.zf;
        end
    end

    // ------------------------------------------------------------------
    // Blend along z: (bot - top) * zf in two partial products
    // ------------------------------------------------------------------
    logic signed [41:0] dz;
    b2_t                b2_reg;

    assign dz = $signed({1'b0, b1_reg.bot}) - $signed({1'b0, b1_reg.top});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            b2_reg <= '0;
        else if (adv)
        begin
            b2_reg.f   <= b1_reg.f;
            b2_reg.top <= b1_reg.top;
            b2_reg.lo  <= 37'(dz[20:0]) * 37'(b1_reg.zf);
            b2_reg.hi  <= $signed(dz[41:21]) * $signed({1'b0, b1_reg.zf});
        end
    end

    logic signed [59:0] acc;
    b3_t                b3_reg;

    assign acc = $signed({3'b000, b2_reg.top, 16'd0})
               + ($signed({{1{b2_reg.hi[37]}}, b2_reg.hi, 21'd0}))
               + $signed({23'd0, b2_reg.lo});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            b3_reg <= '0;
        else if (adv)
        begin
            b3_reg.f   <= b2_reg.f;
            b3_reg.val <= acc[55:32];
        end
    end

    // ------------------------------------------------------------------
    // World scaling: val * dim_y in two halves, then floor divide by 255
    // ------------------------------------------------------------------
    c1_t c1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            c1_reg <= '0;
        else if (adv)
        begin
            c1_reg.f   <= b3_reg.f;
            c1_reg.plo <= 40'(b3_reg.val) * 40'(dimy_reg[15:0]);
            c1_reg.phi <= 40'(b3_reg.val) * 40'(dimy_reg[31:16]);
        end
    end

    dig_t c2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            c2_reg <= '0;
        else if (adv)
        begin
            c2_reg.f   <= c1_reg.f;
            // drop the 2^16 of the divisor first: floor of floor is exact
            c2_reg.y   <= 48'(c1_reg.phi) + 48'(c1_reg.plo >> 16);
            c2_reg.rem <= '0;
            c2_reg.q   <= '0;
        end
    end

    // Long division by 255, one byte per stage from the top
    dig_t dig_reg [DIG_N];

    for (genvar k = 0; k < DIG_N; k++)
    begin : g_digit
        dig_t        din;
        logic [15:0] n;
        logic [16:0] nsum;
        logic [7:0]  qd;
        logic [15:0] rnext;

        if (k == 0)
        begin : g_first
            assign din = c2_reg;
        end
        else
        begin : g_next
            assign din = dig_reg[k-1];
        end

        assign n     = {din.rem, din.y[47:40]};
        assign nsum  = 17'(n) + 17'd1 + 17'(n[15:8]);
        assign qd    = nsum[15:8];
        assign rnext = n - ({qd, 8'd0} - 16'(qd));

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                dig_reg[k] <= '0;
            else if (adv)
            begin
                dig_reg[k].f   <= din.f;
                dig_reg[k].y   <= {din.y[39:0], 8'd0};
                dig_reg[k].rem <= rnext[7:0];
                dig_reg[k].q   <= {din.q[39:0], qd};
            end
        end
    end

    // ------------------------------------------------------------------
    // Offset, saturate and push into the two-entry output buffer
    // ------------------------------------------------------------------
    dig_t               fin;
    logic signed [35:0] world;
    logic [31:0]        sat;
    logic [31:0]        res_height;
    logic               res_outside;
    logic               push;
    logic               pop;
    logic [32:0]        ent0_reg;
    logic [32:0]        ent1_reg;

    assign fin   = dig_reg[DIG_N-1];
    assign world = $signed({2'b00, fin.q[33:0]}) + $signed({{4{miny_reg[31]}}, miny_reg});

    always_comb
    begin
        if (world > 36'sh0_7FFF_FFFF)
            sat = 32'h7FFF_FFFF;
        else if (world < -36'sh0_8000_0000)
            sat = 32'h8000_0000;
        else
            sat = world[31:0];
    end

    assign res_outside = !fin.f.wr && fin.f.outside;
    assign res_height  = (fin.f.wr || fin.f.outside) ? 32'd0 : sat;

    assign push = adv && fin.f.valid;
    assign pop  = m_tvalid && m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            // advance the head; a new beat lands behind what is left
            if (push && (cnt_reg == 2'd1))
                ent0_reg <= {res_outside, res_height};
            else
                ent0_reg <= ent1_reg;
            if (push && (cnt_reg == 2'd2))
                ent1_reg <= {res_outside, res_height};
        end
        else if (push)
        begin
            if (cnt_reg == 2'd0)
                ent0_reg <= {res_outside, res_height};
            else
                ent1_reg <= {res_outside, res_height};
        end
    end

    assign m_tvalid = (cnt_reg != 2'd0);
    assign m_tdata  = ent0_reg[31:0];
    assign m_tuser  = ent0_reg[32];

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_buf_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !push) |=> (cnt_reg == $past(cnt_reg) - 2'd1))
        else $error("output buffer count did not drop on a lone pop");

    a_outside_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[0]) |-> (m_tdata == '0))
        else $error("outside result carries a nonzero height");

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(b3_reg))
        else $error("pipeline moved while the output buffer was full");

    a_bank_split: assert property (@(posedge clk) disable iff (!rst_n)
        (sta_reg.f.valid && !sta_reg.f.wr && !sta_reg.f.outside && sta_reg.dx)
        |-> (sta_reg.sel[0] != sta_reg.sel[1]))
        else $error("horizontal neighbors mapped to the same bank");

endmodule

// ----- tb/hbs_height_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbs_height_checker
// Watches the sampler's channels, predicts every result beat and compares.
// ----------------------------------------------------------------------------
module hbs_height_checker
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [2:0]                    cfg_addr,
    input  logic [31:0]                   cfg_data,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [hbs_pkg::IN_DATA_W-1:0]  s_tdata,
    input  logic [0:0]                    s_tuser,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [hbs_pkg::OUT_DATA_W-1:0] m_tdata,
    input  logic [0:0]                    m_tuser,
    output int                            fail_count,
    output int                            pending
);

    typedef struct packed {
        logic [31:0] height;
        logic        outside;
    } height_result_t;

    logic [hbs_pkg::TEXEL_W-1:0] texels [0:65535];
    height_result_t              expected_heights [$];

    logic [3:0]  width_log2;
    logic [8:0]  map_rows;
    logic        precision;
    logic [31:0] dim_x, dim_z, dim_y, min_y;

    // Map one model coordinate onto texel space; 0 when off the map.
    function automatic bit map_axis(input longint coord, input logic [31:0] dim,
                                    input int span, input bit flip,
                                    output int ip, output int fp);
        longint num;
        longint q;
        ip = 0;
        fp = 0;
        if (dim == 0 || span == 0)
            return 0;
        num = flip ? (longint'(dim) - coord * 131072) : (longint'(dim) + coord * 131072);
        num = num * longint'(span - 1) * 65536;
        if (num < 0)
            return 0;
        q = num / (longint'(dim) * 2);
        if ((q >> 16) >= span)
            return 0;
        ip = int'(q >> 16);
        fp = int'(q & 64'hFFFF);
        return 1;
    endfunction

    function automatic longint texel_q(input int addr);
        logic [23:0] v;
        v = texels[addr];
        return precision ? longint'(v) : (longint'(v[7:0]) << 16);
    endfunction

    function automatic height_result_t predict_height(
        input logic [hbs_pkg::IN_DATA_W-1:0] d);
        height_result_t r;
        int w, h, xi, xf, zi, zf, xn, zn;
        longint h00, h10, h01, h11, top, bot, val, scaled, world;
        r = '0;
        w = 1 << ((width_log2 > 8) ? 8 : width_log2);
        h = (map_rows > 256) ? 256 : map_rows;
        if (!map_axis(longint'($signed(d[15:0])), dim_x, w, 1'b0, xi, xf) ||
            !map_axis(longint'($signed(d[31:16])), dim_z, h, 1'b1, zi, zf))
        begin
            r.outside = 1'b1;
            return r;
        end
        xn = (xi + 1 == w) ? xi : xi + 1;
        zn = (zi + 1 == h) ? zi : zi + 1;
        h00 = texel_q(zi * w + xi);
        h10 = texel_q(zi * w + xn);
        h01 = texel_q(zn * w + xi);
        h11 = texel_q(zn * w + xn);
        top = h00 * (65536 - xf) + h10 * xf;
        bot = h01 * (65536 - xf) + h11 * xf;
        // blend is Q8.48 before the shift
        val = longint'((64'(top) * 64'(65536 - zf) + 64'(bot) * 64'(zf)) >> 32);
        scaled = longint'((64'(val) * 64'(dim_y)) / 64'(255 * 65536));
        world = scaled + longint'($signed(min_y));
        if (world > 64'sd2147483647)
            world = 64'sd2147483647;
        if (world < -64'sd2147483648)
            world = -64'sd2147483648;
        r.height = world[31:0];
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        height_result_t got, want;
        if (!rst_n)
        begin
            width_log2 <= hbs_pkg::RST_WIDTH_LOG2;
            map_rows   <= hbs_pkg::RST_HEIGHT;
            precision  <= hbs_pkg::RST_PRECISION;
            dim_x      <= hbs_pkg::RST_DIM_X;
            dim_z      <= hbs_pkg::RST_DIM_Z;
            dim_y      <= hbs_pkg::RST_DIM_Y;
            min_y      <= hbs_pkg::RST_MIN_Y;
            fail_count <= 0;
            pending    <= 0;
            expected_heights.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                case (hbs_pkg::cfg_reg_t'(cfg_addr))
                    hbs_pkg::REG_WIDTH_LOG2: width_log2 <= cfg_data[3:0];
                    hbs_pkg::REG_HEIGHT:     map_rows   <= cfg_data[8:0];
                    hbs_pkg::REG_PRECISION:  precision  <= cfg_data[0];
                    hbs_pkg::REG_DIM_X:      dim_x      <= cfg_data;
                    hbs_pkg::REG_DIM_Z:      dim_z      <= cfg_data;
                    hbs_pkg::REG_DIM_Y:      dim_y      <= cfg_data;
                    hbs_pkg::REG_MIN_Y:      min_y      <= cfg_data;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
            begin
                if (s_tuser[0])
                begin
                    texels[s_tdata[47:32]] = s_tdata[71:48];
                    expected_heights.insert(expected_heights.size(), '0);
                end
                else
                    expected_heights.insert(expected_heights.size(),
                                            predict_height(s_tdata));
            end
            if (m_tvalid && m_tready)
            begin
                got.height  = m_tdata;
                got.outside = m_tuser[0];
                if (expected_heights.size() == 0)
                begin
                    $display("%0t: unexpected result beat height=%h outside=%b",
                             $time, got.height, got.outside);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = expected_heights.pop_front();
                    if (got.height !== want.height)
                    begin
                        $display("%0t: height expected %h actual %h",
                                 $time, want.height, got.height);
                        fail_count <= fail_count + 1;
                    end
                    if (got.outside !== want.outside)
                    begin
                        $display("%0t: outside_map expected %b actual %b",
                                 $time, want.outside, got.outside);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            pending <= expected_heights.size();
        end
    end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the height-map bilinear sampler.
// ----------------------------------------------------------------------------
// Runs a short directed pass at the reset configuration, then a series of
// configuration phases. Each readable phase first loads every texel of the
// active map, then mixes queries and texel writes with random content. The
// checker beside the sampler predicts each result beat and counts mismatches.
// ----------------------------------------------------------------------------
module testbench;

    localparam int DRAIN_CYCLES  = 64;    // covers the pipeline plus the output buffer
    localparam int IDLE_LIMIT    = 5000;
    localparam int TARGET_ITEMS  = 1550;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          cfg_we = 1'b0;
    logic [2:0]                    cfg_addr = '0;
    logic [31:0]                   cfg_data = '0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [hbs_pkg::IN_DATA_W-1:0]  s_tdata = '0;   // model_x, model_z, texel_addr,
                                                   // texel_value
    logic [0:0]                    s_tuser = '0;   // action
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [hbs_pkg::OUT_DATA_W-1:0] m_tdata;        // height
    logic [0:0]                    m_tuser;        // outside_map

    int fail_count;
    int pending;
    int items_sent = 0;
    int burst_left = 0;
    int idle_cycles = 0;
    int cycle_no = 0;

    heightmap_bilinear_sampler u_top (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    hbs_height_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .fail_count(fail_count), .pending(pending)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Receiver: rotate through four stall patterns, including a
    // stretch of continuous ready.
    always @(posedge clk)
    begin
        cycle_no <= cycle_no + 1;
        case ((cycle_no >> 8) % 4)
            0: m_tready <= 1'b1;
            1: m_tready <= 1'($urandom_range(0, 1));
            2: m_tready <= (cycle_no % 4) != 0;
            default: m_tready <= (cycle_no % 32) < 20;
        endcase
    end

    // Watchdog: count cycles in which no beat moves on either side.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("testbench failed");
            $finish;
        end
    end

    // Send one beat; bursts of random length separated by random gaps.
    task automatic send_beat(input logic action, input logic [hbs_pkg::IN_DATA_W-1:0] data);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= action;
        s_tdata  <= data;
        do
            @(posedge clk);
        while (!s_tready);
        items_sent++;
    endtask

    task automatic send_query(input logic [15:0] x, input logic [15:0] z);
        send_beat(1'b0, {24'h0, 16'h0, z, x});
    endtask

    task automatic send_texel(input logic [15:0] addr, input logic [23:0] value);
        send_beat(1'b1, {value, addr, 16'($urandom_range(0, 65535)),
                         16'($urandom_range(0, 65535))});
    endtask

    // Hold until every expected result has come back and the pipe is empty.
    task automatic drain();
        s_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic load_config(input logic [31:0] regs [7]);
        cfg_we <= 1'b1;
        for (int i = 0; i < 7; i++)
        begin
            cfg_addr <= 3'(hbs_pkg::cfg_reg_t'(i));
            cfg_data <= regs[i];
            @(posedge clk);
        end
        cfg_we <= 1'b0;
    endtask

    function automatic logic [15:0] pick_coord(input logic [31:0] dim);
        int span;
        if ($urandom_range(0, 7) == 0)
            return 16'($urandom_range(0, 65535));
        span = (dim >> 17) + 2;
        if (span > 32767)
            span = 32767;
        return 16'($urandom_range(0, 2 * span) - span);
    endfunction

    // One configuration phase: drain, write all registers, load the active
    // map when it can be read, then mix queries and texel writes.
    task automatic run_phase(input logic [3:0] wl, input logic [8:0] rows,
                             input logic prec, input logic [31:0] dx,
                             input logic [31:0] dz, input logic [31:0] dy,
                             input logic [31:0] my, input bit readable,
                             input int mix_count);
        logic [31:0] regs [7];
        int region;
        drain();
        regs[hbs_pkg::REG_WIDTH_LOG2] = 32'(wl);
        regs[hbs_pkg::REG_HEIGHT]     = 32'(rows);
        regs[hbs_pkg::REG_PRECISION]  = 32'(prec);
        regs[hbs_pkg::REG_DIM_X]      = dx;
        regs[hbs_pkg::REG_DIM_Z]      = dz;
        regs[hbs_pkg::REG_DIM_Y]      = dy;
        regs[hbs_pkg::REG_MIN_Y]      = my;
        load_config(regs);
        region = (1 << ((wl > 8) ? 8 : wl)) * ((rows > 256) ? 256 : rows);
        if (readable)
            for (int a = 0; a < region; a++)
                send_texel(16'(a), 24'($urandom_range(0, 24'hFFFFFF)));
        for (int n = 0; n < mix_count; n++)
        begin
            if ($urandom_range(0, 9) < 7 || !readable)
                send_query(pick_coord(dx), pick_coord(dz));
            else
                send_texel(16'($urandom_range(0, region - 1)),
                           24'($urandom_range(0, 24'hFFFFFF)));
        end
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed at the reset configuration: the map center reads rows and
        // columns 127 and 128 only; any other coordinate falls off the map.
        send_texel(16'd0, 24'h000000);
        send_texel(16'hFFFF, 24'hFFFFFF);
        send_texel(16'(127 * 256 + 127), 24'hFFFFFF);
        send_texel(16'(127 * 256 + 128), 24'h000000);
        send_texel(16'(128 * 256 + 127), 24'h123456);
        send_texel(16'(128 * 256 + 128), 24'hABCDEF);
        send_query(16'd0, 16'd0);
        send_query(16'd1, 16'd0);
        send_query(16'hFFFF, 16'd0);
        send_query(16'd0, 16'd1);
        send_query(16'd0, 16'hFFFF);
        send_query(16'h7FFF, 16'h8000);
        send_query(16'h8000, 16'h7FFF);

        // Extremes: tallest narrow map with saturating height, widest flat map
        // with a zero height range and the lowest offset.
        run_phase(4'd1, 9'd256, 1'b0, 32'h0004_0000, 32'h0040_0000,
                  32'hFFFF_FFFF, 32'h7FFF_FFFF, 1'b1, 60);
        run_phase(4'd8, 9'd1, 1'b1, 32'hFFFF_FFFF, 32'd1,
                  32'd0, 32'h8000_0000, 1'b1, 60);
        // Oversized width and height saturate; zero box width keeps it off the map.
        run_phase(4'd15, 9'd511, 1'b1, 32'd0, 32'h0001_0000,
                  32'h0001_0000, 32'd0, 1'b0, 20);
        // Zero map height and zero box depth: every query is outside.
        run_phase(4'd3, 9'd0, 1'b0, 32'h0008_0000, 32'h0008_0000,
                  32'h0001_0000, 32'd0, 1'b0, 15);
        run_phase(4'd2, 9'd4, 1'b1, 32'h0008_0000, 32'd0,
                  32'h0001_0000, 32'd0, 1'b0, 15);
        // Smallest box: only the origin lands on the map.
        run_phase(4'd2, 9'd3, 1'b0, 32'd1, 32'd1,
                  32'h00FF_0000, 32'hFFFF_0000, 1'b1, 40);

        while (items_sent < TARGET_ITEMS)
            run_phase(4'($urandom_range(1, 4)), 9'($urandom_range(1, 16)),
                      1'($urandom_range(0, 1)),
                      ($urandom_range(1, 40) << 16) | $urandom_range(0, 65535),
                      ($urandom_range(1, 40) << 16) | $urandom_range(0, 65535),
                      $urandom(),
                      $urandom_range(0, 1) ? $urandom() : 32'($urandom_range(0, 1 << 20)),
                      1'b1, 150);

        drain();
        if (fail_count == 0 && pending == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule

// ----- files.f -----
hdl/hbs_pkg.sv
hdl/hbs_coord_div.sv
hdl/heightmap_bilinear_sampler.sv
tb/hbs_height_checker.sv
tb/testbench.sv
